// File: src/latex_prose_mask_scanner_defines.svh
// assertion macros for the checker file of the prose mask scanner
// no dependencies; include guard below
`ifndef LATEX_PROSE_MASK_SCANNER_DEFINES_SVH
`define LATEX_PROSE_MASK_SCANNER_DEFINES_SVH

// generic clocked assertion with an active-low reset
`define LPMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same, on the standard clock and reset names
`define LPMS_ASSERT_STD(lbl, prop, msg) `LPMS_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: src/lpms_pkg.sv
// types and character constants for the prose mask scanner
// no dependencies
package lpms_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] ASCII_TOP  = 8'h80;

  typedef enum logic [7:0] {
    MODE_GAP   = 8'b0000_0001,
    MODE_CMD   = 8'b0000_0010,
    MODE_WORD  = 8'b0000_0100,
    MODE_SKIP  = 8'b0000_1000,
    MODE_OPEN  = 8'b0001_0000,
    MODE_INL   = 8'b0010_0000,
    MODE_DISP  = 8'b0100_0000,
    MODE_CLOSE = 8'b1000_0000
  } scan_mode_e;

  typedef enum logic [3:0] {
    CPH_NONE    = 4'b0001,
    CPH_PERCENT = 4'b0010,
    CPH_BLANK   = 4'b0100,
    CPH_BODY    = 4'b1000
  } comment_phase_e;

  typedef struct packed {
    logic           parity;
    scan_mode_e     mode;
    logic [1:0]     utf8_left;
    comment_phase_e cphase;
  } state_t;

  localparam state_t STATE_RST = '{
    parity:    1'b0,
    mode:      MODE_GAP,
    utf8_left: 2'd0,
    cphase:    CPH_NONE
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       doc_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mask_byte;
    logic       is_content;
    logic       is_comment;
  } result_t;

endpackage

// File: src/lpms_if.sv
// valid/ready channel interfaces for the prose mask scanner
// no dependencies
interface lpms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       doc_start;

  modport source (output valid, text_byte, doc_start, input ready);
  modport sink   (input valid, text_byte, doc_start, output ready);
endinterface

interface lpms_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mask_byte;
  logic       is_content;
  logic       is_comment;

  modport source (output valid, mask_byte, is_content, is_comment, input ready);
  modport sink   (input valid, mask_byte, is_content, is_comment, output ready);
endinterface

// File: src/lpms_in_reg.sv
// input register stage: captures one byte transaction
// depends on lpms_pkg and lpms_in_if
module lpms_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  lpms_in_if.sink           txt_i,
  input  logic              adv_i,
  output logic              valid_o,
  output lpms_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  lpms_pkg::in_item_t item_q;

  assign txt_i.ready = !valid_q || adv_i;

  always_comb begin
    valid_d = valid_q;
    if (txt_i.ready) begin
      valid_d = txt_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (txt_i.valid && txt_i.ready) begin
      item_q <= '{text_byte: txt_i.text_byte, doc_start: txt_i.doc_start};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/lpms_step.sv
// per-byte scanner step: next state and mask result from current state
// depends on lpms_pkg
module lpms_step (
  input  lpms_pkg::state_t   st_i,
  input  lpms_pkg::in_item_t item_i,
  output lpms_pkg::state_t   st_o,
  output lpms_pkg::result_t  res_o
);

  function automatic logic is_break(input logic [7:0] b);
    logic r;
    r = 1'b0;
    if (b < lpms_pkg::ASCII_TOP) begin
      r = b inside {8'h20, [8'h09:8'h0D], [8'h21:8'h2F], [8'h3A:8'h40],
                    [8'h5B:8'h60], [8'h7B:8'h7E]};
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (b == lpms_pkg::CH_AT);
  endfunction

  function automatic logic [1:0] extra_bytes(input logic [7:0] b);
    logic [1:0] r;
    r = 2'd0;
    if (b[7:5] == 3'b110) begin
      r = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      r = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      r = 2'd3;
    end
    return r;
  endfunction

  lpms_pkg::state_t       cur;
  lpms_pkg::scan_mode_e   mode;
  lpms_pkg::comment_phase_e cph;
  logic [7:0]             b;
  logic [7:0]             cb;
  logic [1:0]             left;
  logic                   esc, done, content, cm;
  logic                   is_dollar, is_percent;

  always_comb begin
    cur        = item_i.doc_start ? lpms_pkg::STATE_RST : st_i;
    b          = item_i.text_byte;
    esc        = cur.parity;
    mode       = cur.mode;
    left       = cur.utf8_left;
    cph        = cur.cphase;
    done       = 1'b0;
    content    = 1'b0;
    cm         = 1'b0;
    cb         = b;
    is_dollar  = (b == lpms_pkg::CH_DOLLAR);
    is_percent = (b == lpms_pkg::CH_PERCENT);

    // pending second dollar of a display open or close
    if (mode == lpms_pkg::MODE_OPEN) begin
      if (is_dollar) begin
        mode = lpms_pkg::MODE_DISP;
        done = 1'b1;
      end else begin
        mode = lpms_pkg::MODE_INL;
      end
    end else if (mode == lpms_pkg::MODE_CLOSE) begin
      if (is_dollar) begin
        mode = lpms_pkg::MODE_GAP;
        done = 1'b1;
      end else begin
        mode = lpms_pkg::MODE_DISP;
      end
    end

    if (!done && mode == lpms_pkg::MODE_INL) begin
      if (is_dollar && !esc) mode = lpms_pkg::MODE_GAP;
      done = 1'b1;
    end
    if (!done && mode == lpms_pkg::MODE_DISP) begin
      if (is_dollar && !esc) mode = lpms_pkg::MODE_CLOSE;
      done = 1'b1;
    end
    if (!done && mode == lpms_pkg::MODE_SKIP) begin
      if (b == lpms_pkg::CH_LF) mode = lpms_pkg::MODE_GAP;
      done = 1'b1;
    end
    if (!done && mode == lpms_pkg::MODE_CMD) begin
      if (is_letter(b)) begin
        done = 1'b1;
      end else if (b == lpms_pkg::CH_STAR) begin
        mode = lpms_pkg::MODE_GAP;
        done = 1'b1;
      end else begin
        mode = lpms_pkg::MODE_GAP;
      end
    end
    if (!done && mode == lpms_pkg::MODE_WORD) begin
      if (left != 2'd0) begin
        // claimed continuation byte joins the word unconditionally
        left    = left - 2'd1;
        content = 1'b1;
        done    = 1'b1;
      end else if (!is_break(b)) begin
        left    = extra_bytes(b);
        content = 1'b1;
        done    = 1'b1;
      end else begin
        mode = lpms_pkg::MODE_GAP;
      end
    end
    if (!done) begin
      if (is_percent && !esc) begin
        mode = lpms_pkg::MODE_SKIP;
      end else if (is_dollar && !esc) begin
        mode = lpms_pkg::MODE_OPEN;
      end else if (b == lpms_pkg::CH_BSLASH) begin
        mode = lpms_pkg::MODE_CMD;
      end else if (!is_break(b)) begin
        mode    = lpms_pkg::MODE_WORD;
        left    = extra_bytes(b);
        content = 1'b1;
      end
    end

    // line comment tracking runs independently of the prose scan
    if (b == lpms_pkg::CH_LF) begin
      cph = lpms_pkg::CPH_NONE;
    end else if (cph == lpms_pkg::CPH_NONE) begin
      if (is_percent && !esc) begin
        cph = lpms_pkg::CPH_PERCENT;
        cm  = 1'b1;
        cb  = lpms_pkg::CH_SPACE;
      end
    end else begin
      cm = 1'b1;
      if (cph == lpms_pkg::CPH_PERCENT && is_percent) begin
        cb = lpms_pkg::CH_SPACE;
      end else if (cph != lpms_pkg::CPH_BODY &&
                   (b == lpms_pkg::CH_SPACE || b == lpms_pkg::CH_TAB)) begin
        cph = lpms_pkg::CPH_BLANK;
        cb  = lpms_pkg::CH_SPACE;
      end else begin
        cph = lpms_pkg::CPH_BODY;
      end
    end

    st_o.parity    = (b == lpms_pkg::CH_BSLASH) ? !cur.parity : 1'b0;
    st_o.mode      = mode;
    st_o.utf8_left = left;
    st_o.cphase    = cph;

    if (cm) begin
      res_o.mask_byte = cb;
    end else if (content) begin
      res_o.mask_byte = b;
    end else if (b == lpms_pkg::CH_LF || b == lpms_pkg::CH_CR) begin
      res_o.mask_byte = b;
    end else begin
      res_o.mask_byte = lpms_pkg::CH_SPACE;
    end
    res_o.is_content = content;
    res_o.is_comment = cm;
  end

endmodule

// File: src/lpms_out_reg.sv
// result register stage: holds one mask transaction until taken
// depends on lpms_pkg and lpms_out_if
module lpms_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  lpms_pkg::result_t res_i,
  output logic              free_o,
  lpms_out_if.source        mask_o
);

  logic              valid_q, valid_d;
  lpms_pkg::result_t res_q;

  assign free_o = !valid_q || mask_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (adv_i) begin
      valid_d = 1'b1;
    end else if (mask_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_i;
    end
  end

  assign mask_o.valid      = valid_q;
  assign mask_o.mask_byte  = res_q.mask_byte;
  assign mask_o.is_content = res_q.is_content;
  assign mask_o.is_comment = res_q.is_comment;

endmodule

// File: src/latex_prose_mask_scanner.sv
// channel   | dir | payload                              | handshake
// txt_i     | in  | text_byte[7:0], doc_start            | valid/ready
// mask_o    | out | mask_byte[7:0], is_content, is_comment | valid/ready
//
// one byte per cycle sustained while mask_o is ready; a byte reaches mask_o
// through the input register and then the result register
// the scanner state register updates as a byte moves into the result register
// rst_ni clears valids and scanner state at once; doc_start clears the state
// per document; a stall at mask_o backs up through both registers to txt_i
module latex_prose_mask_scanner (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpms_in_if.sink    txt_i,
  lpms_out_if.source mask_o
);

  logic               in_valid;
  lpms_pkg::in_item_t in_item;
  logic               out_free;
  logic               adv;
  lpms_pkg::state_t   state_q, state_d;
  lpms_pkg::result_t  res;

  assign adv = in_valid && out_free;

  lpms_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .txt_i   (txt_i),
    .adv_i   (adv),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  lpms_step u_step (
    .st_i   (state_q),
    .item_i (in_item),
    .st_o   (state_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpms_pkg::STATE_RST;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  lpms_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .res_i  (res),
    .free_o (out_free),
    .mask_o (mask_o)
  );

endmodule

// File: src/lpms_checker.sv
// port-level checks for the prose mask scanner, bound to the top level
// depends on lpms_pkg and latex_prose_mask_scanner_defines.svh
`include "latex_prose_mask_scanner_defines.svh"

module lpms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] mask_byte_i,
  input logic       is_content_i,
  input logic       is_comment_i
);

  // stalled result holds its payload
  `LPMS_ASSERT_STD(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(mask_byte_i) && $stable(is_content_i) && $stable(is_comment_i), "stalled result changed")

  // an accepted byte is visible at the output
  `LPMS_ASSERT_STD(a_latency, in_valid_i && in_ready_i |-> ##2 out_valid_i, "accepted byte did not reach output")

  // a line feed always ends a comment and is never part of it
  `LPMS_ASSERT_STD(a_comment_no_lf, out_valid_i && is_comment_i |-> mask_byte_i != lpms_pkg::CH_LF, "line feed inside comment")

  // outside words and comments only blanks and line breaks appear
  `LPMS_ASSERT_STD(a_plain_blank, out_valid_i && !is_comment_i && !is_content_i |-> mask_byte_i == lpms_pkg::CH_SPACE || mask_byte_i == lpms_pkg::CH_LF || mask_byte_i == lpms_pkg::CH_CR, "unexpected byte outside prose")

endmodule

bind latex_prose_mask_scanner lpms_checker u_lpms_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (txt_i.valid),
  .in_ready_i   (txt_i.ready),
  .out_valid_i  (mask_o.valid),
  .out_ready_i  (mask_o.ready),
  .mask_byte_i  (mask_o.mask_byte),
  .is_content_i (mask_o.is_content),
  .is_comment_i (mask_o.is_comment)
);
